@@ sv/ssl_pkg.sv @@
// Shared types, constants and the syntax transition function of the statement lexer.
package ssl_pkg;

	localparam int MID_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_OPEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CLOSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COMMA = 2'd2;

	localparam logic [7:0] CNT_MAX = 8'hFF;
	localparam logic [7:0] MAX_RESET = 8'd1;

	typedef enum logic [2:0] {
		CLS_OPEN    = 3'd0,
		CLS_CLOSE   = 3'd1,
		CLS_COMMA   = 3'd2,
		CLS_ALPHA   = 3'd3,
		CLS_DIGIT   = 3'd4,
		CLS_BLANK   = 3'd5,
		CLS_EOL     = 3'd6,
		CLS_ILLEGAL = 3'd7
	} class_t;

	typedef enum logic [3:0] {
		ST_START         = 4'd0,
		ST_ENTER_OPCODE  = 4'd1,
		ST_OPCODE        = 4'd2,
		ST_END_OPCODE    = 4'd3,
		ST_ENTER_OPERAND = 4'd4,
		ST_OPERAND       = 4'd5,
		ST_END_OPERAND   = 4'd6,
		ST_END_STATEMENT = 4'd7,
		ST_DONE          = 4'd8,
		ST_ERROR         = 4'd9
	} state_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       line_start;
	} in_item_t;

	typedef struct packed {
		logic [3:0] next_syntax_state;
		logic [2:0] char_class;
		logic [7:0] open_count;
		logic [7:0] close_count;
		logic [7:0] comma_count;
		logic [7:0] multi_statement_count;
		logic [7:0] bad_first_char_count;
	} out_item_t;

	// Class assuming a non-operand state; hex_letter marks letters that read as digits in operands.
	typedef struct packed {
		class_t pre_class;
		logic   hex_letter;
		logic   line_start;
	} mid_item_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v, input logic en);
		sat_inc = (en && v != CNT_MAX) ? v + 8'd1 : v;
	endfunction

	function automatic state_t next_state(input state_t st, input class_t cls);
		state_t ns;
		ns = ST_ERROR;
		unique case (st)
			ST_START: begin
				case (cls)
					CLS_OPEN:  ns = ST_ENTER_OPCODE;
					CLS_COMMA: ns = ST_ENTER_OPERAND;
					CLS_ALPHA: ns = ST_OPCODE;
					CLS_DIGIT: ns = ST_OPERAND;
					CLS_BLANK: ns = ST_START;
					CLS_EOL:   ns = ST_DONE;
					default:   ns = ST_ERROR;
				endcase
			end
			ST_ENTER_OPCODE: begin
				case (cls)
					CLS_OPEN:  ns = ST_ENTER_OPCODE;
					CLS_CLOSE: ns = ST_END_STATEMENT;
					CLS_COMMA: ns = ST_ENTER_OPERAND;
					CLS_ALPHA: ns = ST_OPCODE;
					CLS_DIGIT: ns = ST_OPERAND;
					CLS_BLANK: ns = ST_ENTER_OPCODE;
					default:   ns = ST_ERROR;
				endcase
			end
			ST_OPCODE: begin
				case (cls)
					CLS_CLOSE: ns = ST_END_STATEMENT;
					CLS_COMMA: ns = ST_ENTER_OPERAND;
					CLS_ALPHA: ns = ST_OPCODE;
					CLS_DIGIT: ns = ST_OPERAND;
					CLS_BLANK: ns = ST_END_OPCODE;
					default:   ns = ST_ERROR;
				endcase
			end
			ST_END_OPCODE: begin
				case (cls)
					CLS_CLOSE: ns = ST_END_STATEMENT;
					CLS_COMMA: ns = ST_ENTER_OPERAND;
					CLS_DIGIT: ns = ST_OPERAND;
					CLS_BLANK: ns = ST_END_OPCODE;
					default:   ns = ST_ERROR;
				endcase
			end
			ST_ENTER_OPERAND: begin
				case (cls)
					CLS_CLOSE: ns = ST_END_STATEMENT;
					CLS_COMMA: ns = ST_DONE;
					CLS_DIGIT: ns = ST_OPERAND;
					CLS_BLANK: ns = ST_ENTER_OPERAND;
					default:   ns = ST_ERROR;
				endcase
			end
			ST_OPERAND: begin
				case (cls)
					CLS_CLOSE: ns = ST_END_STATEMENT;
					CLS_COMMA: ns = ST_DONE;
					CLS_DIGIT: ns = ST_OPERAND;
					CLS_BLANK: ns = ST_END_OPERAND;
					default:   ns = ST_ERROR;
				endcase
			end
			ST_END_OPERAND: begin
				case (cls)
					CLS_CLOSE: ns = ST_END_STATEMENT;
					CLS_COMMA: ns = ST_DONE;
					CLS_BLANK: ns = ST_END_OPERAND;
					default:   ns = ST_ERROR;
				endcase
			end
			ST_END_STATEMENT: begin
				case (cls)
					CLS_CLOSE: ns = ST_END_STATEMENT;
					CLS_COMMA: ns = ST_DONE;
					CLS_BLANK: ns = ST_END_STATEMENT;
					CLS_EOL:   ns = ST_DONE;
					default:   ns = ST_ERROR;
				endcase
			end
			ST_DONE: begin
				case (cls)
					CLS_COMMA: ns = ST_DONE;
					CLS_BLANK: ns = ST_DONE;
					CLS_EOL:   ns = ST_DONE;
					default:   ns = ST_ERROR;
				endcase
			end
			default: ns = ST_ERROR;
		endcase
		next_state = ns;
	endfunction

endpackage

@@ sv/ssl_queue.sv @@
// Small synchronous queue built from registers.
module ssl_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ sv/ssl_front.sv @@
// Front end: classifies each incoming character independently of the syntax state.
module ssl_front (
	input  ssl_pkg::in_item_t  item,
	output ssl_pkg::mid_item_t mid
);

	logic       upper;
	logic       lower;
	logic [7:0] up_char;

	assign upper   = (item.char_in >= "A") && (item.char_in <= "Z");
	assign lower   = (item.char_in >= "a") && (item.char_in <= "z");
	assign up_char = lower ? item.char_in - 8'd32 : item.char_in;

	always_comb begin
		mid.line_start = item.line_start;
		mid.hex_letter = (upper || lower) &&
			(((up_char >= "A") && (up_char <= "F")) || (up_char == "X"));
		if (upper || lower) begin
			mid.pre_class = ssl_pkg::CLS_ALPHA;
		end else if ((item.char_in >= "0") && (item.char_in <= "9")) begin
			mid.pre_class = ssl_pkg::CLS_DIGIT;
		end else if ((item.char_in == " ") || (item.char_in == 8'h09)) begin
			mid.pre_class = ssl_pkg::CLS_BLANK;
		end else if ((item.char_in == 8'h0A) || (item.char_in == 8'h0D)) begin
			mid.pre_class = ssl_pkg::CLS_EOL;
		end else if (item.char_in == ",") begin
			mid.pre_class = ssl_pkg::CLS_COMMA;
		end else if (item.char_in == "{") begin
			mid.pre_class = ssl_pkg::CLS_OPEN;
		end else if (item.char_in == "}") begin
			mid.pre_class = ssl_pkg::CLS_CLOSE;
		end else begin
			mid.pre_class = ssl_pkg::CLS_ILLEGAL;
		end
	end

endmodule

@@ sv/ssl_back.sv @@
// Back end: syntax state, per-line counters, tallies and the limit registers.
module ssl_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [ssl_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [7:0]                          wr_data,
	input  logic                                mid_valid,
	input  ssl_pkg::mid_item_t                  mid,
	output logic                                mid_pop,
	input  logic                                out_full,
	output logic                                out_push,
	output ssl_pkg::out_item_t                  result
);

	logic [7:0]      max_open_q;
	logic [7:0]      max_close_q;
	logic [7:0]      max_comma_q;
	ssl_pkg::state_t state_q;
	logic [7:0]      open_q;
	logic [7:0]      close_q;
	logic [7:0]      comma_q;
	logic [7:0]      multi_q;
	logic [7:0]      bad_q;

	ssl_pkg::state_t st_cur;
	ssl_pkg::state_t st_next;
	ssl_pkg::class_t cls;
	logic            in_operand;
	logic [7:0]      open_n;
	logic [7:0]      close_n;
	logic [7:0]      comma_n;
	logic [7:0]      multi_n;
	logic [7:0]      bad_n;
	logic            over;
	logic            bad_first;
	logic            step;

	assign step     = mid_valid && !out_full;
	assign mid_pop  = step;
	assign out_push = step;

	assign st_cur     = mid.line_start ? ssl_pkg::ST_START : state_q;
	assign in_operand = (st_cur == ssl_pkg::ST_ENTER_OPERAND) ||
		(st_cur == ssl_pkg::ST_OPERAND) || (st_cur == ssl_pkg::ST_END_OPERAND);
	assign cls = (mid.pre_class == ssl_pkg::CLS_ALPHA && mid.hex_letter && in_operand) ?
		ssl_pkg::CLS_DIGIT : mid.pre_class;

	assign open_n  = ssl_pkg::sat_inc(mid.line_start ? 8'd0 : open_q,
		cls == ssl_pkg::CLS_OPEN);
	assign close_n = ssl_pkg::sat_inc(mid.line_start ? 8'd0 : close_q,
		cls == ssl_pkg::CLS_CLOSE);
	assign comma_n = ssl_pkg::sat_inc(mid.line_start ? 8'd0 : comma_q,
		cls == ssl_pkg::CLS_COMMA);

	always_comb begin
		case (cls)
			ssl_pkg::CLS_OPEN:  over = (open_n > max_open_q);
			ssl_pkg::CLS_CLOSE: over = (close_n > max_close_q);
			ssl_pkg::CLS_COMMA: over = (comma_n > max_comma_q);
			default:            over = 1'b0;
		endcase
	end

	assign bad_first = (st_cur == ssl_pkg::ST_START) && (cls != ssl_pkg::CLS_BLANK) &&
		(cls != ssl_pkg::CLS_EOL) && (cls != ssl_pkg::CLS_OPEN);
	assign multi_n = ssl_pkg::sat_inc(mid.line_start ? 8'd0 : multi_q, over);
	assign bad_n   = ssl_pkg::sat_inc(mid.line_start ? 8'd0 : bad_q, bad_first);
	assign st_next = ssl_pkg::next_state(st_cur, cls);

	always_comb begin
		result.next_syntax_state     = st_next;
		result.char_class            = cls;
		result.open_count            = open_n;
		result.close_count           = close_n;
		result.comma_count           = comma_n;
		result.multi_statement_count = multi_n;
		result.bad_first_char_count  = bad_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_open_q  <= ssl_pkg::MAX_RESET;
			max_close_q <= ssl_pkg::MAX_RESET;
			max_comma_q <= ssl_pkg::MAX_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				ssl_pkg::REG_MAX_OPEN:  max_open_q  <= wr_data;
				ssl_pkg::REG_MAX_CLOSE: max_close_q <= wr_data;
				ssl_pkg::REG_MAX_COMMA: max_comma_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssl_pkg::ST_START;
			open_q  <= '0;
			close_q <= '0;
			comma_q <= '0;
			multi_q <= '0;
			bad_q   <= '0;
		end else if (step) begin
			state_q <= st_next;
			open_q  <= open_n;
			close_q <= close_n;
			comma_q <= comma_n;
			multi_q <= multi_n;
			bad_q   <= bad_n;
		end
	end

endmodule

@@ sv/statement_syntax_lexer_top.sv @@
// Top level of the statement syntax lexer.
// The lexer takes one character per clock, unless a full queue holds it off, and returns one
// result per character. A character pushed into the lexer is classified on the way into a
// short queue, then resolved against the syntax state and line counters by the back end and
// written into the result queue, from whose head it is taken. The back end updates its state
// for each character it takes, which sets the sustained rate of one character per clock; the
// two queues buffer between the sides, so a stall on one side stops the other once one fills.
module statement_syntax_lexer_top #(
	parameter int MID_DEPTH = ssl_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = ssl_pkg::OUT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ssl_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data,
	input  logic                          push,
	input  ssl_pkg::in_item_t             item,
	output logic                          full,
	input  logic                          pop,
	output ssl_pkg::out_item_t            result,
	output logic                          empty
);

	localparam int MID_W = $bits(ssl_pkg::mid_item_t);
	localparam int OUT_W = $bits(ssl_pkg::out_item_t);

	ssl_pkg::mid_item_t mid_in;
	ssl_pkg::mid_item_t mid_out;
	ssl_pkg::out_item_t back_result;
	logic               mid_empty;
	logic               mid_pop;
	logic               out_full;
	logic               out_push;

	ssl_front u_front (
		.item (item),
		.mid  (mid_in)
	);

	ssl_queue #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (mid_in),
		.full   (full),
		.pop    (mid_pop),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	ssl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.mid_valid (!mid_empty),
		.mid       (mid_out),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.result    (back_result)
	);

	ssl_queue #(
		.WIDTH (OUT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (back_result),
		.full   (out_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule

@@ dv/lexer_result_checker.sv @@
`timescale 1ns / 100ps
// Watches the lexer's character and result channels, predicts each result and compares it.
module lexer_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ssl_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]                    wr_data,
	input  logic                          push,
	input  ssl_pkg::in_item_t             item,
	input  logic                          full,
	input  logic                          pop,
	input  ssl_pkg::out_item_t            result,
	input  logic                          empty,
	output int                            mismatch_count,
	output int                            chars_in_flight
);

	ssl_pkg::state_t step_table [10][8] = '{
		'{ssl_pkg::ST_ENTER_OPCODE, ssl_pkg::ST_ERROR, ssl_pkg::ST_ENTER_OPERAND,
			ssl_pkg::ST_OPCODE, ssl_pkg::ST_OPERAND, ssl_pkg::ST_START,
			ssl_pkg::ST_DONE, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ENTER_OPCODE, ssl_pkg::ST_END_STATEMENT, ssl_pkg::ST_ENTER_OPERAND,
			ssl_pkg::ST_OPCODE, ssl_pkg::ST_OPERAND, ssl_pkg::ST_ENTER_OPCODE,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ERROR, ssl_pkg::ST_END_STATEMENT, ssl_pkg::ST_ENTER_OPERAND,
			ssl_pkg::ST_OPCODE, ssl_pkg::ST_OPERAND, ssl_pkg::ST_END_OPCODE,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ERROR, ssl_pkg::ST_END_STATEMENT, ssl_pkg::ST_ENTER_OPERAND,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_OPERAND, ssl_pkg::ST_END_OPCODE,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ERROR, ssl_pkg::ST_END_STATEMENT, ssl_pkg::ST_DONE,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_OPERAND, ssl_pkg::ST_ENTER_OPERAND,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ERROR, ssl_pkg::ST_END_STATEMENT, ssl_pkg::ST_DONE,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_OPERAND, ssl_pkg::ST_END_OPERAND,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ERROR, ssl_pkg::ST_END_STATEMENT, ssl_pkg::ST_DONE,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR, ssl_pkg::ST_END_OPERAND,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ERROR, ssl_pkg::ST_END_STATEMENT, ssl_pkg::ST_DONE,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR, ssl_pkg::ST_END_STATEMENT,
			ssl_pkg::ST_DONE, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR, ssl_pkg::ST_DONE,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR, ssl_pkg::ST_DONE,
			ssl_pkg::ST_DONE, ssl_pkg::ST_ERROR},
		'{ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR,
			ssl_pkg::ST_ERROR, ssl_pkg::ST_ERROR}
	};

	logic [7:0]         lim_open;
	logic [7:0]         lim_close;
	logic [7:0]         lim_comma;
	ssl_pkg::state_t    lex_state;
	logic [7:0]         n_open;
	logic [7:0]         n_close;
	logic [7:0]         n_comma;
	logic [7:0]         n_multi;
	logic [7:0]         n_bad_first;
	ssl_pkg::out_item_t lexed_q [$];
	ssl_pkg::out_item_t want;

	function automatic logic [7:0] bump(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic void clear_line();
		lex_state = ssl_pkg::ST_START;
		n_open = '0;
		n_close = '0;
		n_comma = '0;
		n_multi = '0;
		n_bad_first = '0;
	endfunction

	function automatic ssl_pkg::class_t char_kind(input logic [7:0] c,
		input ssl_pkg::state_t st);
		logic [7:0] up;
		logic       in_operand;
		in_operand = (st == ssl_pkg::ST_ENTER_OPERAND) || (st == ssl_pkg::ST_OPERAND) ||
			(st == ssl_pkg::ST_END_OPERAND);
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
			up = c & 8'hDF;
			if (in_operand && ((up >= "A" && up <= "F") || up == "X"))
				return ssl_pkg::CLS_DIGIT;
			return ssl_pkg::CLS_ALPHA;
		end
		if (c >= "0" && c <= "9") return ssl_pkg::CLS_DIGIT;
		if (c == " " || c == 8'h09) return ssl_pkg::CLS_BLANK;
		if (c == 8'h0A || c == 8'h0D) return ssl_pkg::CLS_EOL;
		if (c == ",") return ssl_pkg::CLS_COMMA;
		if (c == "{") return ssl_pkg::CLS_OPEN;
		if (c == "}") return ssl_pkg::CLS_CLOSE;
		return ssl_pkg::CLS_ILLEGAL;
	endfunction

	function automatic ssl_pkg::out_item_t lex_char(input logic [7:0] ch, input logic ls);
		ssl_pkg::class_t    cls;
		ssl_pkg::state_t    st;
		ssl_pkg::out_item_t r;
		if (ls) clear_line();
		st = lex_state;
		cls = char_kind(ch, st);
		case (cls)
			ssl_pkg::CLS_OPEN: begin
				n_open = bump(n_open);
				if (n_open > lim_open) n_multi = bump(n_multi);
			end
			ssl_pkg::CLS_CLOSE: begin
				n_close = bump(n_close);
				if (n_close > lim_close) n_multi = bump(n_multi);
			end
			ssl_pkg::CLS_COMMA: begin
				n_comma = bump(n_comma);
				if (n_comma > lim_comma) n_multi = bump(n_multi);
			end
			default: ;
		endcase
		if (st == ssl_pkg::ST_START && cls != ssl_pkg::CLS_BLANK &&
			cls != ssl_pkg::CLS_EOL && cls != ssl_pkg::CLS_OPEN)
			n_bad_first = bump(n_bad_first);
		lex_state = step_table[st][cls];
		r.next_syntax_state = lex_state;
		r.char_class = cls;
		r.open_count = n_open;
		r.close_count = n_close;
		r.comma_count = n_comma;
		r.multi_statement_count = n_multi;
		r.bad_first_char_count = n_bad_first;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_open = ssl_pkg::MAX_RESET;
			lim_close = ssl_pkg::MAX_RESET;
			lim_comma = ssl_pkg::MAX_RESET;
			clear_line();
			lexed_q.delete();
			mismatch_count = 0;
			chars_in_flight = 0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					ssl_pkg::REG_MAX_OPEN:  lim_open = wr_data;
					ssl_pkg::REG_MAX_CLOSE: lim_close = wr_data;
					ssl_pkg::REG_MAX_COMMA: lim_comma = wr_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (lexed_q.size() == 0) begin
					$error("Result transfer with no character outstanding");
					mismatch_count++;
				end else begin
					want = lexed_q.pop_front();
					check_field("next_syntax_state", 8'(want.next_syntax_state),
						8'(result.next_syntax_state));
					check_field("char_class", 8'(want.char_class), 8'(result.char_class));
					check_field("open_count", want.open_count, result.open_count);
					check_field("close_count", want.close_count, result.close_count);
					check_field("comma_count", want.comma_count, result.comma_count);
					check_field("multi_statement_count", want.multi_statement_count,
						result.multi_statement_count);
					check_field("bad_first_char_count", want.bad_first_char_count,
						result.bad_first_char_count);
				end
			end
			if (push && !full)
				lexed_q.push_back(lex_char(item.char_in, item.line_start));
			chars_in_flight = lexed_q.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top: drives characters, limit writes and result stalls into the statement lexer.
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_CHARS = 100;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          wr_en = 1'b0;
	logic [ssl_pkg::CFG_IDX_W-1:0] wr_index = ssl_pkg::REG_MAX_OPEN;
	logic [7:0]                    wr_data = '0;
	logic                          push = 1'b0;
	ssl_pkg::in_item_t             item = '0;
	logic                          full;
	logic                          pop = 1'b0;
	ssl_pkg::out_item_t            result;
	logic                          empty;
	int                            mismatch_count;
	int                            chars_in_flight;
	int                            cycle_count = 0;
	logic                          steady = 1'b0;
	logic [7:0]                    line_q [$];

	statement_syntax_lexer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.item     (item),
		.full     (full),
		.pop      (pop),
		.result   (result),
		.empty    (empty)
	);

	lexer_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.push            (push),
		.item            (item),
		.full            (full),
		.pop             (pop),
		.result          (result),
		.empty           (empty),
		.mismatch_count  (mismatch_count),
		.chars_in_flight (chars_in_flight)
	);

	initial forever #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial forever begin
		@(negedge clk);
		pop <= steady || ($urandom_range(99) >= 29);
	end

	task automatic send_char(input logic [7:0] ch, input logic ls);
		while (!steady && $urandom_range(99) < 29) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= '{char_in: ch, line_start: ls};
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (chars_in_flight != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_limits(input logic [7:0] mo, input logic [7:0] mc, input logic [7:0] mm);
		wr_en <= 1'b1;
		wr_index <= ssl_pkg::REG_MAX_OPEN;
		wr_data <= mo;
		@(negedge clk);
		wr_index <= ssl_pkg::REG_MAX_CLOSE;
		wr_data <= mc;
		@(negedge clk);
		wr_index <= ssl_pkg::REG_MAX_COMMA;
		wr_data <= mm;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic add_blanks();
		repeat ($urandom_range(2)) line_q.push_back($urandom_range(1) ? " " : "\t");
	endtask

	// Mostly well-formed statements with random content, some doubled, some mangled or noise.
	task automatic build_line();
		logic [7:0] ch;
		line_q.delete();
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(255)));
			return;
		end
		repeat (($urandom_range(99) < 20) ? 2 : 1) begin
			add_blanks();
			line_q.push_back("{");
			add_blanks();
			if ($urandom_range(99) < 90)
				repeat ($urandom_range(1, 4)) begin
					ch = 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
					line_q.push_back(ch);
				end
			add_blanks();
			line_q.push_back(",");
			add_blanks();
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(2))
					0: ch = 8'("0" + $urandom_range(9));
					1: ch = 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(5));
					default: ch = $urandom_range(1) ? "x" : "X";
				endcase
				line_q.push_back(ch);
			end
			add_blanks();
			line_q.push_back("}");
			add_blanks();
		end
		case ($urandom_range(3))
			0: line_q.push_back("\n");
			1: line_q.push_back(8'h0D);
			2: line_q.push_back(",");
			default: begin
				line_q.push_back(8'h0D);
				line_q.push_back("\n");
			end
		endcase
		foreach (line_q[i])
			if ($urandom_range(99) < 4) line_q[i] = 8'($urandom_range(255));
	endtask

	task automatic random_lines(input int n_chars);
		int   sent;
		logic first_ls;
		sent = 0;
		while (sent < n_chars) begin
			build_line();
			first_ls = $urandom_range(99) < 90;
			foreach (line_q[i])
				send_char(line_q[i], (i == 0) ? first_ls : ($urandom_range(99) < 2));
			sent += line_q.size();
		end
	endtask

	// One long line of braces and commas in random order, to drive the open and multi-statement counters to saturation.
	task automatic flood_punct(input int n_open, input int n_close, input int n_comma);
		int   left [3];
		int   k;
		logic first;
		left = '{n_open, n_close, n_comma};
		first = 1'b1;
		while (left[0] + left[1] + left[2] > 0) begin
			k = $urandom_range(2);
			if (left[k] == 0) continue;
			left[k]--;
			send_char((k == 0) ? "{" : ((k == 1) ? "}" : ","), first);
			first = 1'b0;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_char("{", 1'b1);
		send_char("A", 1'b0);
		send_char("b", 1'b0);
		send_char(",", 1'b0);
		send_char(" ", 1'b0);
		send_char("9", 1'b0);
		send_char("f", 1'b0);
		send_char("X", 1'b0);
		send_char("}", 1'b0);
		send_char("\n", 1'b0);
		send_char("\t", 1'b1);
		send_char(8'h0D, 1'b0);
		send_char("z", 1'b1);
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b0);
		send_char("{", 1'b0);
		send_char(",", 1'b1);
		send_char(8'h80, 1'b0);
		send_char(",", 1'b1);
		send_char("e", 1'b0);
		send_char(8'h0B, 1'b1);
		send_char(8'h0C, 1'b0);
		send_char("{", 1'b1);
		send_char("{", 1'b0);
		send_char("}", 1'b0);
		drain();

		set_limits(8'd0, 8'd0, 8'd0);
		random_lines(PHASE_CHARS);
		drain();

		steady = 1'b1;
		set_limits(8'd255, 8'd255, 8'd255);
		random_lines(PHASE_CHARS);
		drain();
		steady = 1'b0;

		set_limits(8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3)));
		random_lines(PHASE_CHARS);
		drain();

		set_limits(8'd3, 8'd1, 8'd2);
		random_lines(PHASE_CHARS);
		drain();

		set_limits(8'd0, 8'd255, 8'd1);
		flood_punct(258, 8, 8);
		drain();

		if (mismatch_count == 0 && chars_in_flight == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
